// ===== sv/fasr_pkg.sv =====
// Shared types and constants for the fraction add/subtract/reduce block.
package fasr_pkg;

    localparam int NumW = 33;
    localparam int DenW = 32;
    localparam int MagW = 33;   // magnitude width for the divider
    localparam int CntW = 6;

    localparam logic ReqAdd = 1'b0;
    localparam logic ReqSub = 1'b1;

    typedef enum logic [1:0] {
        OP_REM  = 2'd0,   // remainder of r_a by r_b
        OP_QNUM = 2'd1,   // quotient raw_num / g
        OP_QDEN = 2'd2    // quotient raw_den / g
    } t_div_op;

    typedef struct packed {
        logic    load;      // capture the operands and form the products
        logic    sum;       // form the raw numerator and denominator
        logic    div_start; // start a divide
        t_div_op div_op;
        logic    step_euclid; // shift (a,b) <- (b,r)
        logic    take_qnum;
        logic    take_qden;
        logic    set_error;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic den_zero;
    } t_status;

endpackage

// ===== sv/fasr_datapath.sv =====
// Datapath: products, raw sums, Euclid registers and a restoring divider.
module fasr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fasr_pkg::t_cmd                i_cmd,
    output fasr_pkg::t_status             o_status,
    input  logic                          i_req_type,
    input  logic signed [15:0]            i_num_a,
    input  logic signed [15:0]            i_den_a,
    input  logic signed [15:0]            i_num_b,
    input  logic signed [15:0]            i_den_b,
    output logic signed [fasr_pkg::NumW-1:0] o_raw_num,
    output logic signed [fasr_pkg::DenW-1:0] o_raw_den,
    output logic signed [fasr_pkg::NumW-1:0] o_reduced_num,
    output logic signed [fasr_pkg::DenW-1:0] o_reduced_den
);
    localparam int W = fasr_pkg::MagW;

    logic              r_sub;
    logic signed [31:0] r_p_left, r_p_right, r_p_den;
    logic signed [W-1:0] r_raw_num, r_raw_den, r_a, r_b;
    logic signed [W-1:0] r_qn, r_qd;

    // divider state
    logic [W-1:0]      r_dvd, r_dvs, r_rem;
    logic [fasr_pkg::CntW-1:0] r_cnt;
    logic              r_busy, r_done, r_neg_q, r_neg_r;
    fasr_pkg::t_div_op r_op;
    logic signed [W-1:0] r_res;
    logic              r_done_d;

    logic signed [W-1:0] div_a, div_b;
    logic [W:0]          trial;
    logic [W-1:0]        rem_sh;

    always_comb begin
        case (i_cmd.div_op)
            fasr_pkg::OP_REM:  begin div_a = r_a;       div_b = r_b; end
            fasr_pkg::OP_QNUM: begin div_a = r_raw_num; div_b = r_b; end
            fasr_pkg::OP_QDEN: begin div_a = r_raw_den; div_b = r_b; end
            default:           begin div_a = r_a;       div_b = r_b; end
        endcase
        rem_sh = {r_rem[W-2:0], r_dvd[W-1]};
        trial  = {1'b0, rem_sh} - {1'b0, r_dvs};
    end

    // divider sequencing; done is reported in the cycle after r_done, once r_res is valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_done_d <= 1'b0;
        end else begin
            r_done_d <= r_done;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_busy <= (r_cnt != fasr_pkg::CntW'(1));
                r_done <= (r_cnt == fasr_pkg::CntW'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sub     <= i_req_type;
            r_p_left  <= 32'(i_num_a * i_den_b);
            r_p_right <= 32'(i_den_a * i_num_b);
            r_p_den   <= 32'(i_den_a * i_den_b);
        end
        if (i_cmd.sum) begin
            if (r_sub == fasr_pkg::ReqSub) begin
                r_raw_num <= W'(r_p_left) - W'(r_p_right);
            end else begin
                r_raw_num <= W'(r_p_left) + W'(r_p_right);
            end
            r_raw_den <= W'(r_p_den);
            r_a       <= W'(r_p_left) + (r_sub ? -W'(r_p_right) : W'(r_p_right));
            r_b       <= W'(r_p_den);
        end
        if (i_cmd.step_euclid) begin
            r_a <= r_b;
            r_b <= r_res;
        end
        if (i_cmd.div_start) begin
            r_op    <= i_cmd.div_op;
            r_dvd   <= div_a[W-1] ? W'(-div_a) : div_a;
            r_dvs   <= div_b[W-1] ? W'(-div_b) : div_b;
            r_rem   <= '0;
            r_cnt   <= fasr_pkg::CntW'(W);
            r_neg_q <= div_a[W-1] ^ div_b[W-1];
            r_neg_r <= div_a[W-1];
        end else if (r_busy) begin
            if (trial[W]) begin
                r_rem <= rem_sh;
                r_dvd <= {r_dvd[W-2:0], 1'b0};
            end else begin
                r_rem <= trial[W-1:0];
                r_dvd <= {r_dvd[W-2:0], 1'b1};
            end
            r_cnt <= r_cnt - fasr_pkg::CntW'(1);
        end
        if (r_done) begin
            // quotient sits in r_dvd, remainder in r_rem
            if (r_op == fasr_pkg::OP_REM) begin
                r_res <= r_neg_r ? -$signed(r_rem) : $signed(r_rem);
            end else begin
                r_res <= r_neg_q ? -$signed(r_dvd) : $signed(r_dvd);
            end
        end
        if (i_cmd.set_error) begin
            r_qn <= '0;
            r_qd <= '0;
        end else begin
            if (i_cmd.take_qnum) r_qn <= r_res;
            if (i_cmd.take_qden) r_qd <= r_res;
        end
    end

    assign o_status.div_done = r_done_d;
    assign o_status.rem_zero = (r_res == '0);
    assign o_status.den_zero = (r_p_den == '0);

    assign o_raw_num     = r_raw_num;
    assign o_raw_den     = fasr_pkg::DenW'(r_raw_den);
    assign o_reduced_num = r_qn;
    assign o_reduced_den = fasr_pkg::DenW'(r_qd);
endmodule

// ===== sv/fasr_ctrl.sv =====
// Controller: sequences load, Euclid remainder loop and the two divisions.
module fasr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_err,
    output fasr_pkg::t_cmd     o_cmd,
    input  fasr_pkg::t_status  i_status
);
    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_CHECK, S_REM, S_QNUM, S_QDEN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid, r_err;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_err   = r_err;

    always_comb begin
        o_cmd = '0;
        o_cmd.div_op = fasr_pkg::OP_REM;
        case (r_state)
            S_IDLE:  o_cmd.load = i_valid;
            S_SUM:   o_cmd.sum = 1'b1;
            S_CHECK: begin
                if (i_status.den_zero) begin
                    o_cmd.set_error = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_REM: begin
                if (i_status.div_done) begin
                    if (i_status.rem_zero) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_op    = fasr_pkg::OP_QNUM;
                    end else begin
                        o_cmd.step_euclid = 1'b1;
                    end
                end
            end
            S_QNUM: begin
                o_cmd.div_op = fasr_pkg::OP_QDEN;
                if (i_status.div_done) begin
                    o_cmd.take_qnum = 1'b1;
                    o_cmd.div_start = 1'b1;
                end
            end
            S_QDEN:  o_cmd.take_qden = i_status.div_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_SUM;
                S_SUM:   r_state <= S_CHECK;
                S_CHECK: begin
                    r_err <= i_status.den_zero;
                    if (i_status.den_zero) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_REM;
                    end
                end
                S_REM: begin
                    // after a non-zero remainder the next divide starts from S_CHECK in the following cycle
                    if (i_status.div_done && i_status.rem_zero) r_state <= S_QNUM;
                    else if (i_status.div_done) r_state <= S_CHECK;
                end
                S_QNUM:  if (i_status.div_done) r_state <= S_QDEN;
                S_QDEN: begin
                    if (i_status.div_done) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/fraction_add_sub_reduce.sv =====
// Top level: fraction add/subtract with Euclidean reduction.
// Usage:
//   Input word: i_req_type, i_num_a, i_den_a, i_num_b, i_den_b with i_valid;
//   taken when i_valid is high and o_stall is low. o_stall is high while an
//   item is in work or its result waits, so one item is held at a time.
//   Output word: o_raw_num, o_raw_den, o_reduced_num, o_reduced_den,
//   o_den_zero_error with o_valid; taken when o_valid is high and i_stall low.
// Sequencing:
//   One shared restoring divider does every remainder of the Euclid loop and
//   both exact divisions. Each remainder step starts its divide in S_CHECK
//   and waits in S_REM; the two divisions wait in S_QNUM and S_QDEN. A zero
//   denominator skips the divider: S_SUM, S_CHECK (sets the error), S_OUT.
//   A new item is taken only after the last result has left S_OUT.
// Reset: synchronous active-low i_rst_n returns to idle and drops o_valid.
// Stall: a result is held unchanged while i_stall is high.
module fraction_add_sub_reduce (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic signed [15:0]         i_num_a,
    input  logic signed [15:0]         i_den_a,
    input  logic signed [15:0]         i_num_b,
    input  logic signed [15:0]         i_den_b,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [32:0]         o_raw_num,
    output logic signed [31:0]         o_raw_den,
    output logic signed [32:0]         o_reduced_num,
    output logic signed [31:0]         o_reduced_den,
    output logic                       o_den_zero_error
);
    fasr_pkg::t_cmd    cmd;
    fasr_pkg::t_status status;

    fasr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_err    (o_den_zero_error),
        .o_cmd    (cmd),
        .i_status (status)
    );

    fasr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_req_type),
        .i_num_a       (i_num_a),
        .i_den_a       (i_den_a),
        .i_num_b       (i_num_b),
        .i_den_b       (i_den_b),
        .o_raw_num     (o_raw_num),
        .o_raw_den     (o_raw_den),
        .o_reduced_num (o_reduced_num),
        .o_reduced_den (o_reduced_den)
    );

    a_busy_while_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while input open");
    a_err_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_den_zero_error) |-> (o_reduced_num == '0 && o_reduced_den == '0))
        else $error("reduced outputs not zero on error");
    a_err_raw_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_den_zero_error == (o_raw_den == '0)))
        else $error("error flag disagrees with raw denominator");
endmodule
